[sv/hsmp_pkg.sv]
// Shared types, constants and helpers for the Halton sample generator.
package hsmp_pkg;

    localparam int NUM_DIMS_DEF  = 7;
    localparam int FRAC_BITS_DEF = 32;
    localparam int TABLE_DEPTH   = 7;
    localparam int IDX_W         = 31;
    localparam int VAL_W         = 32;
    localparam int PTR_W         = 3;
    localparam int DIG_W         = 5;
    localparam int NUM_STEPS     = 31;
    localparam int STEP_W        = 5;

    localparam int PRIMES [TABLE_DEPTH] = '{2, 3, 5, 7, 11, 13, 17};

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_NEXT  = 2'd1,
        KIND_DRAW1 = 2'd2,
        KIND_DRAW2 = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  sample_index;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0]  first_value;
        logic [VAL_W-1:0]  second_value;
        logic              is_pair;
    } t_out_item;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [STEP_W-1:0] step_idx;
    } t_lane_ctl;

    // Number of base-b digits an index below 2^IDX_W can have.
    function automatic int num_digits(input int b);
        longint p;
        int     d;
        p = 1;
        d = 0;
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (p < (longint'(1) << IDX_W)) begin
                p = p * b;
                d = d + 1;
            end
        end
        return d;
    endfunction

endpackage

[sv/hsmp_lane.sv]
// One radical-inverse lane: peels one base digit per cycle while stepped and accumulates its weight.
module hsmp_lane #(
    parameter int BASE      = 2,
    parameter int FRAC_BITS = hsmp_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hsmp_pkg::t_lane_ctl         i_ctl,
    input  logic [hsmp_pkg::IDX_W-1:0]  i_fill_idx,
    output logic [hsmp_pkg::VAL_W-1:0]  o_value
);
    import hsmp_pkg::*;

    localparam int          LOG_B  = $clog2(BASE);
    localparam int          SHIFT  = IDX_W + LOG_B;
    localparam logic [63:0] RECIP  = ((64'd1 << SHIFT) / BASE) + 64'd1;
    localparam int          NDIG   = num_digits(BASE);
    localparam logic [DIG_W-1:0] BASE_D = DIG_W'(BASE);

    logic [FRAC_BITS-1:0]       w_tab [NUM_STEPS];
    logic [IDX_W-1:0]           r_rest;
    logic [IDX_W-1:0]           r_prev;
    logic                       r_pv;
    logic [STEP_W-1:0]          r_k;
    logic [FRAC_BITS-1:0]       r_acc;
    logic [63:0]                prod;
    logic [IDX_W-1:0]           quo;
    logic [DIG_W-1:0]           digit;
    logic [FRAC_BITS+DIG_W-1:0] term;

    // digit weights floor(2^FRAC_BITS / BASE^(k+1)); digits past the last one weigh zero
    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_w
        if (k < NDIG) begin : g_live
            localparam logic [63:0] WK = (64'd1 << FRAC_BITS) / (64'(BASE) ** (k + 1));
            assign w_tab[k] = WK[FRAC_BITS-1:0];
        end else begin : g_dead
            assign w_tab[k] = '0;
        end
    end

    // exact quotient by reciprocal multiply for any index below 2^IDX_W
    assign prod  = 64'(r_rest) * RECIP;
    assign quo   = IDX_W'(prod >> SHIFT);
    // remainder is below BASE, so the low bits alone give it
    assign digit = r_prev[DIG_W-1:0] - r_rest[DIG_W-1:0] * BASE_D;
    assign term  = digit * w_tab[r_k];

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_prev <= r_rest;
            r_rest <= quo;
            r_k    <= i_ctl.step_idx;
        end else if (i_ctl.load) begin
            r_rest <= i_fill_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else if (i_ctl.load) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= i_ctl.step;
            if (r_pv) begin
                r_acc <= r_acc + term[FRAC_BITS-1:0];
            end
        end
    end

    if (FRAC_BITS >= VAL_W) begin : g_out_cut
        assign o_value = r_acc[VAL_W-1:0];
    end else begin : g_out_ext
        assign o_value = VAL_W'(r_acc);
    end

endmodule

[sv/hsmp_seq.sv]
// Fill sequencer: holds the sample counter and steps all lanes through the digits.
module hsmp_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_set,
    input  logic [hsmp_pkg::IDX_W-1:0]  i_idx,
    output logic                        o_busy,
    output hsmp_pkg::t_lane_ctl         o_ctl,
    output logic [hsmp_pkg::IDX_W-1:0]  o_fill_idx
);
    import hsmp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_sample;
    logic               last_step;

    assign last_step  = (r_cnt == STEP_W'(NUM_STEPS));
    assign o_fill_idx = i_set ? i_idx : r_sample;
    assign o_busy     = (r_state == S_FILL);

    assign o_ctl.load     = i_start;
    assign o_ctl.step     = (r_state == S_FILL) && !last_step;
    assign o_ctl.step_idx = r_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                // the final count, with no step, lets the last digit reach the accumulators
                if (last_step) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + STEP_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_sample <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_start) begin
                r_sample <= i_set ? i_idx : r_sample + IDX_W'(1);
            end
        end
    end

endmodule

[sv/halton_sampler_core.sv]
// Halton sample generator top level: request decode, dimension pointer, result register.
//
//  channel | direction | valid        | stall        | payload
//  --------+-----------+--------------+--------------+----------------------------
//  request | in        | i_in_valid   | o_in_stall   | i_in_item  (t_in_item)
//  result  | out       | o_out_valid  | i_out_stall  | o_out_item (t_out_item)
//
//  A set or next request keeps the request side stalled after its transfer while
//  the lanes step through every digit of the base-2 lane, the longest, then drain.
//  A draw yields one registered result; it waits while a held result is stalled.
//  Set and next requests are still taken while a result waits at the output.
//  Reset clears the table, sample counter, pointer and output valid.
module halton_sampler_core #(
    parameter int NUM_DIMS  = hsmp_pkg::NUM_DIMS_DEF,
    parameter int FRAC_BITS = hsmp_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  hsmp_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output hsmp_pkg::t_out_item  o_out_item
);
    import hsmp_pkg::*;

    logic [VAL_W-1:0]   vals [NUM_DIMS];
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic [PTR_W-1:0]   ptr_q;
    logic               r_out_vld;
    t_out_item          r_out;
    logic               busy;
    logic               is_draw;
    logic               accept;
    logic               start;
    t_lane_ctl          lane_ctl;
    logic [IDX_W-1:0]   fill_idx;
    logic [VAL_W-1:0]   val_p;
    logic [VAL_W-1:0]   val_q;

    assign is_draw    = (i_in_item.kind == KIND_DRAW1) || (i_in_item.kind == KIND_DRAW2);
    assign o_in_stall = busy || (is_draw && r_out_vld && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign start      = accept && !is_draw;

    hsmp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_set      (i_in_item.kind == KIND_SET),
        .i_idx      (i_in_item.sample_index),
        .o_busy     (busy),
        .o_ctl      (lane_ctl),
        .o_fill_idx (fill_idx)
    );

    for (genvar d = 0; d < NUM_DIMS; d++) begin : g_lane
        hsmp_lane #(
            .BASE      (PRIMES[d]),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (lane_ctl),
            .i_fill_idx (fill_idx),
            .o_value    (vals[d])
        );
    end

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(NUM_DIMS - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign ptr_q = wrap_inc(r_ptr);

    always_comb begin
        val_p = '0;
        val_q = '0;
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (r_ptr == PTR_W'(d)) begin
                val_p = vals[d];
            end
            if (ptr_q == PTR_W'(d)) begin
                val_q = vals[d];
            end
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (accept) begin
            case (i_in_item.kind)
                KIND_DRAW1: n_ptr = ptr_q;
                KIND_DRAW2: n_ptr = wrap_inc(ptr_q);
                default:    n_ptr = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_ptr <= n_ptr;
            if (accept && is_draw) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_draw) begin
            r_out.first_value  <= val_p;
            r_out.is_pair      <= (i_in_item.kind == KIND_DRAW2);
            r_out.second_value <= (i_in_item.kind == KIND_DRAW2) ? val_q : '0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr < PTR_W'(NUM_DIMS))
        else $error("dimension pointer out of range");

    a_single_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.is_pair) |-> (o_out_item.second_value == '0))
        else $error("single draw carries a second value");

    a_fill_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (busy && o_in_stall && (r_ptr == '0)))
        else $error("fill request did not start the sequencer");

    a_draw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_draw) |=> o_out_valid)
        else $error("draw produced no result");

    a_no_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !accept)
        else $error("request taken during table fill");

endmodule

[tb/hsmp_draw_checker.sv]
// Request/result monitor with a Halton table predictor and an in-order result compare.
`timescale 1ns / 100ps

module hsmp_draw_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  hsmp_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  hsmp_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count
);
    import hsmp_pkg::*;

    localparam int DIMS = NUM_DIMS_DEF;

    logic [VAL_W-1:0] frac_table [TABLE_DEPTH];
    logic [IDX_W-1:0] index_reg;
    int unsigned      dim_sel;
    t_out_item        draws_due [$];
    int               fails   = 0;
    int               checked = 0;

    // Sum of digit * floor(2^FRAC_BITS / base^k), truncated per weight.
    function automatic logic [VAL_W-1:0] reverse_digits(input logic [IDX_W-1:0] index,
                                                        input int unsigned base);
        longint unsigned unit;
        longint unsigned power;
        longint unsigned acc;
        longint unsigned rest;
        unit  = 64'd1 << FRAC_BITS_DEF;
        power = base;
        acc   = 0;
        rest  = index;
        while (rest != 0) begin
            acc   = acc + (rest % base) * (unit / power);
            rest  = rest / base;
            power = power * base;
        end
        return VAL_W'(acc);
    endfunction

    task automatic refill(input logic [IDX_W-1:0] index);
        for (int d = 0; d < DIMS; d++) begin
            frac_table[d] = reverse_digits(index, PRIMES[d]);
        end
        dim_sel = 0;
    endtask

    task automatic take_request(input t_in_item req);
        t_out_item   due;
        int unsigned nxt;
        nxt = (dim_sel + 1) % DIMS;
        case (req.kind)
            KIND_SET: begin
                index_reg = req.sample_index;
                refill(index_reg);
            end
            KIND_NEXT: begin
                refill(index_reg);
                index_reg = index_reg + 1'b1;
            end
            KIND_DRAW1: begin
                due.first_value  = frac_table[dim_sel];
                due.second_value = '0;
                due.is_pair      = 1'b0;
                draws_due.push_back(due);
                dim_sel = nxt;
            end
            KIND_DRAW2: begin
                due.first_value  = frac_table[dim_sel];
                due.second_value = frac_table[nxt];
                due.is_pair      = 1'b1;
                draws_due.push_back(due);
                dim_sel = (nxt + 1) % DIMS;
            end
        endcase
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (draws_due.size() == 0) begin
            $error("result with no draw pending: first_value %h second_value %h is_pair %b",
                   got.first_value, got.second_value, got.is_pair);
            fails++;
        end else begin
            want = draws_due.pop_front();
            checked++;
            if (got.first_value !== want.first_value) begin
                $error("first_value: expected %h, got %h", want.first_value, got.first_value);
                fails++;
            end
            if (got.second_value !== want.second_value) begin
                $error("second_value: expected %h, got %h", want.second_value,
                       got.second_value);
                fails++;
            end
            if (got.is_pair !== want.is_pair) begin
                $error("is_pair: expected %b, got %b", want.is_pair, got.is_pair);
                fails++;
            end
        end
    endtask

    // Take the request first so a same-cycle result still lines up in order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (frac_table[d]) frac_table[d] = '0;
            index_reg = '0;
            dim_sel   = 0;
            draws_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) take_request(i_in_item);
            if (i_out_valid && !i_out_stall) check_result(i_out_item);
        end
        o_pending      <= draws_due.size();
        o_fail_count   <= fails;
        o_result_count <= checked;
    end

endmodule

[tb/tb_halton_sampler_core.sv]
// Testbench top: clock, reset, request stimulus, result stall pattern, watchdog and verdict.
`timescale 1ns / 100ps

module tb_halton_sampler_core;
    import hsmp_pkg::*;

    localparam int               IDLE_LIMIT  = 4000;
    localparam int               PHASE_ITEMS = 350;
    localparam logic [IDX_W-1:0] MAX_INDEX   = '1;

    logic      clk         = 1'b0;
    logic      rst_n       = 1'b0;
    logic      req_valid   = 1'b0;
    logic      req_stall;
    t_in_item  req_item    = '0;
    logic      res_valid;
    logic      res_stall   = 1'b0;
    t_out_item res_item;

    int        fail_count;
    int        res_pending;
    int        res_count;
    logic      calm        = 1'b0;
    int        stall_run   = 0;
    int        stall_pick;
    int        idle_cycles = 0;
    int        n_set       = 0;
    int        n_next      = 0;
    int        n_draw1     = 0;
    int        n_draw2     = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    halton_sampler_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_item   (req_item),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_item  (res_item)
    );

    hsmp_draw_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (req_valid),
        .i_in_stall     (req_stall),
        .i_in_item      (req_item),
        .i_out_valid    (res_valid),
        .i_out_stall    (res_stall),
        .i_out_item     (res_item),
        .o_fail_count   (fail_count),
        .o_pending      (res_pending),
        .o_result_count (res_count)
    );

    // Result side back-pressure: mostly open, short holds, an occasional long one.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (calm || stall_pick < 55) begin
                res_stall <= 1'b0;
                stall_run <= $urandom_range(0, 8);
            end else if (stall_pick < 90) begin
                res_stall <= 1'b1;
                stall_run <= $urandom_range(0, 2);
            end else if (stall_pick < 97) begin
                res_stall <= 1'b1;
                stall_run <= $urandom_range(3, 11);
            end else begin
                res_stall <= 1'b1;
                stall_run <= $urandom_range(20, 60);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("halton_sampler_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IDX_W-1:0] random_index();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return IDX_W'($urandom_range(0, 64));
        if (r == 1) return MAX_INDEX - IDX_W'($urandom_range(0, 3));
        return IDX_W'($urandom);
    endfunction

    function automatic t_in_item make_req(input t_kind kind, input logic [IDX_W-1:0] index);
        t_in_item r;
        r.kind         = kind;
        r.sample_index = index;
        return r;
    endfunction

    function automatic t_in_item random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return make_req(KIND_SET, random_index());
        if (r < 25) return make_req(KIND_NEXT, random_index());
        if (r < 62) return make_req(KIND_DRAW1, random_index());
        return make_req(KIND_DRAW2, random_index());
    endfunction

    // Hold valid across back-to-back transfers; drop it only for a gap.
    task automatic send_request(input t_in_item req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= req;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        case (req.kind)
            KIND_SET:   n_set++;
            KIND_NEXT:  n_next++;
            KIND_DRAW1: n_draw1++;
            KIND_DRAW2: n_draw2++;
        endcase
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (res_pending != 0);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset table, then pair draws that wrap the pointer past the last dimension
        send_request(make_req(KIND_DRAW1, random_index()));
        send_request(make_req(KIND_DRAW2, random_index()));
        send_request(make_req(KIND_SET, MAX_INDEX));
        send_request(make_req(KIND_DRAW2, random_index()));
        send_request(make_req(KIND_DRAW2, random_index()));
        send_request(make_req(KIND_DRAW2, random_index()));
        send_request(make_req(KIND_DRAW2, random_index()));
        // counter wraps to zero, then a fill from index zero
        send_request(make_req(KIND_NEXT, random_index()));
        send_request(make_req(KIND_DRAW1, random_index()));
        send_request(make_req(KIND_NEXT, random_index()));
        send_request(make_req(KIND_DRAW2, random_index()));
        send_request(make_req(KIND_SET, 31'h2AAAAAAA));
        send_request(make_req(KIND_DRAW1, random_index()));
        send_request(make_req(KIND_DRAW2, random_index()));
        send_request(make_req(KIND_DRAW1, random_index()));
        send_request(make_req(KIND_SET, 31'h55555555));
        send_request(make_req(KIND_DRAW2, random_index()));
        send_request(make_req(KIND_NEXT, random_index()));
        send_request(make_req(KIND_DRAW1, random_index()));
        send_request(make_req(KIND_SET, 31'd1));
        send_request(make_req(KIND_DRAW1, random_index()));
        send_request(make_req(KIND_DRAW1, random_index()));
        send_request(make_req(KIND_DRAW2, random_index()));
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            calm <= (phase == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
            drain_results();
        end

        repeat (40) @(posedge clk);
        $display("requests sent: %0d set, %0d next, %0d single draw, %0d pair draw",
                 n_set, n_next, n_draw1, n_draw2);
        $display("draw results compared: %0d, including a gap-free phase and drained pauses",
                 res_count);
        if (fail_count == 0) begin
            $display("halton_sampler_core: match");
        end else begin
            $display("halton_sampler_core: mismatch");
        end
        $finish;
    end

endmodule
